>>> sv/tmhpc_pkg.sv
// ----------------------------------------------------------------------------
// tmhpc_pkg
// Types and constants shared by the pump controller modules.
// ----------------------------------------------------------------------------
package tmhpc_pkg;

  localparam int WINDOW     = 5;
  localparam int SLOT_W     = 3;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  typedef logic signed [7:0] deg_t;
  typedef logic [15:0]       tick_t;
  typedef logic [6:0]        err_t;
  typedef logic [7:0]        status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ON_THRESHOLD  = 8'd0,
    CFG_OFF_THRESHOLD = 8'd1,
    CFG_FAULT_TIMEOUT = 8'd2,
    CFG_STATUS_PERIOD = 8'd3
  } cfg_idx_t;

  localparam logic OP_SAMPLE   = 1'b0;
  localparam logic OP_TICK     = 1'b1;
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam deg_t    RESET_ON_THRESHOLD  = 8'sd55;
  localparam deg_t    RESET_OFF_THRESHOLD = 8'sd40;
  localparam tick_t   RESET_FAULT_TIMEOUT = 16'd50000;
  localparam tick_t   RESET_STATUS_PERIOD = 16'd3000;
  localparam deg_t    RING_ENTRY0_RESET   = -8'sd127;
  localparam status_t PROT_TRIP_BIT       = 8'b1000_0000;

endpackage

>>> sv/tmhpc_trim_mean.sv
// ----------------------------------------------------------------------------
// tmhpc_trim_mean
// Mean of the middle three of five ring entries, truncated toward zero.
// ----------------------------------------------------------------------------
module tmhpc_trim_mean
  import tmhpc_pkg::*;
(
  input  deg_t ring [WINDOW],
  output deg_t mean
);

  localparam int SUM_W  = 11;
  localparam int MAG_W  = 9;
  localparam int PROD_W = 18;
  localparam int RECIP_SHIFT = 9;
  localparam logic [PROD_W-1:0] RECIP_THIRD = 18'd171;

  // The middle three entries sum to the total less the minimum and maximum.
  deg_t                     lo;
  deg_t                     hi;
  logic signed [SUM_W-1:0]  total;
  logic signed [SUM_W-1:0]  mid;
  logic                     neg;
  logic [SUM_W-1:0]         mag;
  logic [PROD_W-1:0]        prod;
  logic [7:0]               quot;

  always_comb begin
    lo    = ring[0];
    hi    = ring[0];
    total = SUM_W'(ring[0]);
    for (int i = 1; i < WINDOW; i++) begin
      if (ring[i] < lo) lo = ring[i];
      if (ring[i] > hi) hi = ring[i];
      total = total + SUM_W'(ring[i]);
    end
    mid  = total - SUM_W'(lo) - SUM_W'(hi);
    neg  = mid[SUM_W-1];
    mag  = neg ? SUM_W'(-mid) : SUM_W'(mid);
    prod = PROD_W'(mag[MAG_W-1:0]) * RECIP_THIRD;
    quot = prod[RECIP_SHIFT+7:RECIP_SHIFT];
    mean = neg ? deg_t'(-quot) : deg_t'(quot);
  end

endmodule

>>> sv/trimmed_mean_hysteresis_pump_control.sv
// ----------------------------------------------------------------------------
// trimmed_mean_hysteresis_pump_control
// Hysteresis pump control driven by a trimmed-mean temperature filter.
// ----------------------------------------------------------------------------
// An item's result enters the output register in the cycle after its acceptance.
// One item is accepted every cycle while the output register is empty or being
// taken; a new item may enter in the same cycle as the held result is taken.
// Synchronous active-low reset restores thresholds, timers, ring and pump state.
// ----------------------------------------------------------------------------
module trimmed_mean_hysteresis_pump_control
  import tmhpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // whole_degrees, sensor_error, protection_ok, raw_word
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // op
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // pump_on, trimmed_mean, status_byte, report_word, forced_on, sensor_resync
  output logic [OUT_DATA_W-1:0] out_tdata,
  // kind
  output logic                  out_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  deg_t              on_thr_r, off_thr_r;
  tick_t             timeout_r, period_r;
  deg_t              ring_r [WINDOW];
  deg_t              ring_nxt [WINDOW];
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              pump_r, pump_nxt;
  tick_t             fault_r, fault_nxt;
  tick_t             stat_r, stat_nxt;
  status_t           prev_r, prev_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic    in_acc;
  deg_t    deg;
  err_t    err;
  logic    prot;
  logic [31:0] raw;
  deg_t    mean;
  tick_t   fault_eff;
  logic [16:0] fault_inc;
  tick_t   stat_inc;
  logic    emit;
  logic    flag;
  logic    forced;
  status_t status;
  logic    resync;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

  assign deg  = in_tdata[7:0];
  assign err  = in_tdata[14:8];
  assign prot = in_tdata[15];
  assign raw  = in_tdata[47:16];

  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      ring_nxt[i] = (slot_r == SLOT_W'(i)) ? deg : ring_r[i];
    end
  end

  tmhpc_trim_mean u_trim (
    .ring (ring_nxt),
    .mean (mean)
  );

  always_comb begin
    fault_eff = (err == '0) ? '0 : fault_r;
    forced    = fault_eff >= timeout_r;
    flag      = pump_r;
    if (!pump_r) begin
      if (mean >= on_thr_r) flag = 1'b1;
    end else begin
      if (mean <= off_thr_r) flag = 1'b0;
    end
    if (forced) flag = 1'b1;
    status    = {!prot, err};
    resync    = (prev_r != '0) && (status == '0);
    fault_inc = {1'b0, fault_r} + 17'd1;
    stat_inc  = stat_r + 16'd1;
    emit      = stat_inc >= period_r;
  end

  always_comb begin
    slot_nxt      = slot_r;
    pump_nxt      = pump_r;
    fault_nxt     = fault_r;
    stat_nxt      = stat_r;
    prev_nxt      = prev_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_data_nxt  = out_data_r;
    if (in_acc) begin
      if (in_tuser == OP_TICK) begin
        fault_nxt = (fault_inc >= {1'b0, timeout_r}) ? timeout_r : fault_inc[15:0];
        stat_nxt  = emit ? '0 : stat_inc;
        if (emit) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_STATUS;
          out_data_nxt  = {{(OUT_DATA_W-1){1'b0}}, pump_r};
        end
      end else begin
        slot_nxt      = (slot_r == SLOT_W'(WINDOW-1)) ? '0 : slot_r + SLOT_W'(1);
        fault_nxt     = fault_eff;
        pump_nxt      = flag;
        prev_nxt      = status;
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_REPORT;
        out_data_nxt  = {5'b0, resync, forced, raw, status, mean, flag};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_thr_r    <= RESET_ON_THRESHOLD;
      off_thr_r   <= RESET_OFF_THRESHOLD;
      timeout_r   <= RESET_FAULT_TIMEOUT;
      period_r    <= RESET_STATUS_PERIOD;
      for (int i = 0; i < WINDOW; i++) begin
        ring_r[i] <= (i == 0) ? RING_ENTRY0_RESET : '0;
      end
      slot_r      <= '0;
      pump_r      <= 1'b0;
      fault_r     <= '0;
      stat_r      <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ON_THRESHOLD:  on_thr_r  <= cfg_data[7:0];
          CFG_OFF_THRESHOLD: off_thr_r <= cfg_data[7:0];
          CFG_FAULT_TIMEOUT: timeout_r <= cfg_data;
          CFG_STATUS_PERIOD: period_r  <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc && in_tuser == OP_SAMPLE) begin
        ring_r <= ring_nxt;
      end
      slot_r      <= slot_nxt;
      pump_r      <= pump_nxt;
      fault_r     <= fault_nxt;
      stat_r      <= stat_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_data_r <= out_data_nxt;
  end

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r < SLOT_W'(WINDOW))
    else $error("write slot out of range");

  a_sample_reports: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser == OP_SAMPLE |=> out_valid_r && out_kind_r == KIND_REPORT)
    else $error("sample item did not produce a report");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_STATUS |-> out_data_r[OUT_DATA_W-1:1] == '0)
    else $error("status result carries report fields");

  a_forced_pump: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[49] |-> out_data_r[0])
    else $error("forced result without pump on");

endmodule
